FILE: src/tcp_scan_reply_classifier_assert.svh
// Assertion macros for the top-level file, which checks its own logic.
`ifndef TCP_SCAN_REPLY_CLASSIFIER_ASSERT_SVH
`define TCP_SCAN_REPLY_CLASSIFIER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSRC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tsrc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TSRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsrc: next-cycle check failed");

`endif

FILE: src/tsrc_pkg.sv
package tsrc_pkg;

  typedef logic [2:0] cfg_index_t;
  typedef logic [2:0] reply_class_t;
  typedef logic [1:0] verdict_t;

  // Configuration register indexes.
  localparam cfg_index_t REG_SCAN_MODE    = 3'd0;
  localparam cfg_index_t REG_TARGET_ADDR  = 3'd1;
  localparam cfg_index_t REG_LOCAL_ADDR   = 3'd2;
  localparam cfg_index_t REG_REPLY_PORT   = 3'd3;
  localparam cfg_index_t REG_PORT_FIRST   = 3'd4;
  localparam cfg_index_t REG_PORT_LAST    = 3'd5;
  localparam cfg_index_t REG_SENSITIVE_ON = 3'd6;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_SINGLE = 2'd1,
    MODE_SUBNET = 2'd2
  } scan_mode_t;

  localparam verdict_t VERDICT_IGNORED = 2'd0;
  localparam verdict_t VERDICT_FIRST   = 2'd1;
  localparam verdict_t VERDICT_OTHER   = 2'd2;

  localparam reply_class_t CLASS_NONE    = 3'd0;
  localparam reply_class_t CLASS_SYNACK  = 3'd1;
  localparam reply_class_t CLASS_RSTACK  = 3'd2;
  localparam reply_class_t CLASS_SYNACKF = 3'd3;
  localparam reply_class_t CLASS_ACK     = 3'd4;

  localparam logic [7:0] PROTO_TCP = 8'd6;

  localparam int FLAG_FIN = 0;
  localparam int FLAG_SYN = 1;
  localparam int FLAG_RST = 2;
  localparam int FLAG_ACK = 4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;   // write one empty entry of the clearing pass
    logic load;    // capture an accepted header and read its table entry
    logic commit;  // register the result and update the table
  } tsrc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;  // clearing pass is at its last entry
    logic out_free;  // result register can take a new result this cycle
  } tsrc_sts_t;

  function automatic reply_class_t classify(input logic [5:0] flags);
    logic syn;
    logic ack;
    logic fin;
    logic rst_f;
    reply_class_t cls;
    syn   = flags[FLAG_SYN];
    ack   = flags[FLAG_ACK];
    fin   = flags[FLAG_FIN];
    rst_f = flags[FLAG_RST];
    if (syn && ack && !fin) begin
      cls = CLASS_SYNACK;
    end else if (rst_f && ack) begin
      cls = CLASS_RSTACK;
    end else if (syn && ack && fin) begin
      cls = CLASS_SYNACKF;
    end else if (!syn && ack && !fin) begin
      cls = CLASS_ACK;
    end else begin
      cls = CLASS_NONE;
    end
    return cls;
  endfunction

endpackage

FILE: src/tsrc_ifs.sv
interface tsrc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] source_ip;
  logic [31:0] dest_ip;
  logic [7:0]  ip_protocol;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [5:0]  tcp_flag_bits;

  modport source(output valid, source_ip, dest_ip, ip_protocol, source_port, dest_port,
                 tcp_flag_bits, input ready);
  modport sink(input valid, source_ip, dest_ip, ip_protocol, source_port, dest_port,
               tcp_flag_bits, output ready);
endinterface

interface tsrc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [2:0]  reply_class;
  logic [15:0] entry_index;

  modport source(output valid, verdict, reply_class, entry_index, input ready);
  modport sink(input valid, verdict, reply_class, entry_index, output ready);
endinterface

interface tsrc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: src/tsrc_ctrl.sv
module tsrc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              pkt_valid,
  output logic              pkt_ready,
  input  tsrc_pkg::tsrc_sts_t sts,
  output tsrc_pkg::tsrc_cmd_t cmd
);
  import tsrc_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (sts.clr_done) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (pkt_valid) state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (sts.out_free) state <= ST_IDLE;
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  always_comb begin
    pkt_ready  = (state == ST_IDLE);
    cmd.clear  = (state == ST_CLEAR);
    cmd.load   = (state == ST_IDLE) && pkt_valid;
    cmd.commit = (state == ST_DECIDE) && sts.out_free;
  end

endmodule

FILE: src/tsrc_dp.sv
module tsrc_dp #(
  parameter int TABLE_DEPTH = 65536
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tsrc_pkg::tsrc_cmd_t   cmd,
  output tsrc_pkg::tsrc_sts_t   sts,
  input  logic                  cfg_valid,
  input  tsrc_pkg::cfg_index_t  cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic [31:0]           source_ip,
  input  logic [31:0]           dest_ip,
  input  logic [7:0]            ip_protocol,
  input  logic [15:0]           source_port,
  input  logic [15:0]           dest_port,
  input  logic [5:0]            tcp_flag_bits,
  output logic                  res_valid,
  input  logic                  res_ready,
  output tsrc_pkg::verdict_t    res_verdict,
  output tsrc_pkg::reply_class_t res_class,
  output logic [15:0]           res_index
);
  import tsrc_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [16:0] DEPTH17 = 17'(TABLE_DEPTH);

  // Configuration registers.
  logic [1:0]  scan_mode;
  logic [31:0] target_addr;
  logic [31:0] local_addr;
  logic [15:0] reply_port;
  logic [15:0] port_first;
  logic [15:0] port_last;
  logic        sensitive_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode    <= MODE_OFF;
      target_addr  <= '0;
      local_addr   <= '0;
      reply_port   <= '0;
      port_first   <= '0;
      port_last    <= 16'hFFFF;
      sensitive_on <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SCAN_MODE:    scan_mode    <= cfg_data[1:0];
        REG_TARGET_ADDR:  target_addr  <= cfg_data;
        REG_LOCAL_ADDR:   local_addr   <= cfg_data;
        REG_REPLY_PORT:   reply_port   <= cfg_data[15:0];
        REG_PORT_FIRST:   port_first   <= cfg_data[15:0];
        REG_PORT_LAST:    port_last    <= cfg_data[15:0];
        REG_SENSITIVE_ON: sensitive_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Decode of the incoming header against the configuration.
  logic         tcp_ok;
  logic [15:0]  port_off;
  logic         cand_in;
  logic [15:0]  slot_in;
  logic         sens_in;

  always_comb begin
    tcp_ok = (ip_protocol == PROTO_TCP) && (dest_port == reply_port) &&
             (tcp_flag_bits[FLAG_SYN] || tcp_flag_bits[FLAG_ACK] || tcp_flag_bits[FLAG_RST]);
    port_off = source_port - port_first;
    sens_in  = sensitive_on && (source_ip == target_addr) && (dest_ip == local_addr);
    unique case (scan_mode)
      MODE_SINGLE: begin
        slot_in = port_off;
        cand_in = tcp_ok && (source_ip == target_addr) && (source_port >= port_first) &&
                  (source_port <= port_last) && ({1'b0, port_off} < DEPTH17);
      end
      MODE_SUBNET: begin
        slot_in = {8'h00, source_ip[7:0]};
        cand_in = tcp_ok && ({1'b0, slot_in} < DEPTH17);
      end
      default: begin
        slot_in = '0;
        cand_in = 1'b0;
      end
    endcase
  end

  // Captured item.
  logic         cand;
  logic [15:0]  slot;
  reply_class_t cls;
  logic         sens;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cand <= cand_in;
      slot <= slot_in;
      cls  <= classify(tcp_flag_bits);
      sens <= sens_in;
    end
  end

  // Reply table with its clearing pass.
  logic [AW-1:0] clr_addr;
  reply_class_t  table_mem [TABLE_DEPTH];
  reply_class_t  rd_data;
  logic          hit;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  reply_class_t  mem_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear && !sts.clr_done) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign hit = cand && (rd_data == CLASS_NONE);

  always_comb begin
    if (cmd.clear) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = CLASS_NONE;
    end else begin
      mem_we    = cmd.commit && hit && (cls != CLASS_NONE);
      mem_waddr = slot[AW-1:0];
      mem_wdata = cls;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) table_mem[mem_waddr] <= mem_wdata;
    if (cmd.load) rd_data <= table_mem[slot_in[AW-1:0]];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.commit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (hit) begin
        res_verdict <= VERDICT_FIRST;
        res_class   <= cls;
        res_index   <= slot;
      end else begin
        res_verdict <= sens ? VERDICT_OTHER : VERDICT_IGNORED;
        res_class   <= CLASS_NONE;
        res_index   <= '0;
      end
    end
  end

  assign sts.clr_done = (clr_addr == AW'(TABLE_DEPTH - 1));
  assign sts.out_free = !res_valid || res_ready;

endmodule

FILE: src/tcp_scan_reply_classifier.sv
// Channel | Direction | Payload
// pkt     | in        | source_ip, dest_ip, ip_protocol, source_port, dest_port, tcp_flag_bits
// res     | out       | verdict, reply_class, entry_index
// cfg     | in        | index (register number), data (value written)
//
// Each header's table entry is read as it is accepted in the idle state, and the result and
// any table update are made in the decide state, which waits while the output register is
// full; no new header is taken until then, since the table has a registered read port.
// After reset a clearing pass empties all TABLE_DEPTH entries of the table, one entry a cycle;
// pkt.ready stays low during it, while configuration writes are taken as ever.
// A result waits in the output register; a stalled sink keeps the next item in the decide state.
`include "tcp_scan_reply_classifier_assert.svh"

module tcp_scan_reply_classifier #(
  parameter int TABLE_DEPTH = 65536
) (
  input logic         clk,
  input logic         rst,
  tsrc_in_if.sink     pkt,
  tsrc_out_if.source  res,
  tsrc_cfg_if.sink    cfg
);
  import tsrc_pkg::*;

  tsrc_cmd_t cmd;
  tsrc_sts_t sts;
  logic      pkt_ready;
  logic      res_other;
  logic      res_bare;

  // Configuration registers may be written at any time; the block only promises
  // coherent results when they are written while it is idle.
  assign cfg.ready = 1'b1;
  assign pkt.ready = pkt_ready;

  // The controller sequences the clearing pass, acceptance and the decision step.
  tsrc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (pkt.valid),
    .pkt_ready (pkt_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the configuration, the reply table and the result register.
  tsrc_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_valid     (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .source_ip     (pkt.source_ip),
    .dest_ip       (pkt.dest_ip),
    .ip_protocol   (pkt.ip_protocol),
    .source_port   (pkt.source_port),
    .dest_port     (pkt.dest_port),
    .tcp_flag_bits (pkt.tcp_flag_bits),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_verdict   (res.verdict),
    .res_class     (res.reply_class),
    .res_index     (res.entry_index)
  );

  // A presented result that is not a first reply, and a result with empty class and slot.
  assign res_other = res.valid && (res.verdict != VERDICT_FIRST);
  assign res_bare  = (res.reply_class == CLASS_NONE) && (res.entry_index == 16'd0);

  // Only one header is in flight, so a transfer is never followed at once by another.
  `TSRC_ASSERT_NEXT(a_one_item, pkt.valid && pkt.ready, !pkt.ready)
  // Results other than a first reply carry no class and no table slot.
  `TSRC_ASSERT_SAME(a_quiet_fields, res_other, res_bare)
  // A result is only committed when the output register can take it.
  `TSRC_ASSERT_SAME(a_commit_free, cmd.commit, sts.out_free)

endmodule
